>>> sv/bch_26_16_burst_decoder_assert.svh
// ----------------------------------------------------------------------------
// bch_26_16_burst_decoder_assert.svh
// Assertion macros for the burst decoder back end.
// ----------------------------------------------------------------------------
`ifndef BCH_26_16_BURST_DECODER_ASSERT_SVH
`define BCH_26_16_BURST_DECODER_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define BCHBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BCHBD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/bchbd_pkg.sv
// ----------------------------------------------------------------------------
// bchbd_pkg
// Types, constants and syndrome helpers for the BCH(26,16) burst decoder.
// ----------------------------------------------------------------------------
package bchbd_pkg;

  localparam int CwBits      = 26;
  localparam int ParBits     = 10;
  localparam int DataBits    = 16;
  localparam int BurstBits   = 5;
  localparam int BurstSpan   = 22;
  localparam int ShiftBits   = 5;
  localparam int TotalBits   = 15;
  localparam int QueueDepthDef = 2;

  localparam logic [ParBits:0]     GenPoly  = 11'h5B9;
  localparam logic [TotalBits-1:0] BytesCap = 15'd32766;

  typedef enum logic [1:0] {
    STAT_CLEAN = 2'd0,
    STAT_CORR  = 2'd1,
    STAT_UNCOR = 2'd2,
    STAT_SKIP  = 2'd3
  } status_e;

  // One classified group as it travels from front to back.
  typedef struct packed {
    logic [CwBits-1:0]  cw;
    logic               eom;
    logic [ParBits-1:0] syn;
    logic               clean;
  } item_t;

  typedef logic [ParBits-1:0] syn_tab_t [CwBits];

  // Residue of x^b modulo the generator for every codeword bit.
  function automatic syn_tab_t build_syn_tab();
    syn_tab_t          t;
    logic [ParBits:0]  r;
    r = 11'd1;
    for (int b = 0; b < CwBits; b++) begin
      t[b] = r[ParBits-1:0];
      r = r << 1;
      if (r[ParBits]) r = r ^ GenPoly;
    end
    return t;
  endfunction

  localparam syn_tab_t SynTab = build_syn_tab();

  // Syndrome as the XOR of the residues of the set bits.
  function automatic logic [ParBits-1:0] syndrome(input logic [CwBits-1:0] cw);
    logic [ParBits-1:0] s;
    s = '0;
    for (int b = 0; b < CwBits; b++) begin
      if (cw[b]) s = s ^ SynTab[b];
    end
    return s;
  endfunction

  // Multiply a residue by x^-1 modulo the generator.
  function automatic logic [ParBits-1:0] div_x(input logic [ParBits-1:0] r);
    logic [ParBits:0] t;
    t = {1'b0, r} ^ (r[0] ? GenPoly : '0);
    return t[ParBits:1];
  endfunction

endpackage

>>> sv/bch_26_16_burst_decoder.sv
// Path: clean or skipped group, through the queue and the output register;
//   corrected or uncorrectable group: pop, 22 search steps, finish.
// Throughput: one clean or skipped group per cycle while output is taken and
//   no search runs; a search holds the back end, one residue step per shift.
// Reset clears the queue, the byte count, the failure flag and output valid.
// ----------------------------------------------------------------------------
// bch_26_16_burst_decoder
// Shortened BCH(26,16) decoder with burst correction and message byte totals.
// ----------------------------------------------------------------------------
module bch_26_16_burst_decoder #(
  parameter int QueueDepth = bchbd_pkg::QueueDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bchbd_pkg::CwBits-1:0]    codeword_i,
  input  logic                            end_of_message_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bchbd_pkg::DataBits-1:0]  data_word_o,
  output logic [1:0]                      group_status_o,
  output logic                            message_done_o,
  output logic [bchbd_pkg::TotalBits-1:0] byte_total_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  bchbd_pkg::item_t f_item;
  bchbd_pkg::item_t q_item;

  // Classify incoming beats.
  bchbd_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .codeword_i       (codeword_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push),
    .item_o           (f_item),
    .full_i           (full)
  );

  // Hold classified groups.
  bchbd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Search, account and deliver.
  bchbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_word_o    (data_word_o),
    .group_status_o (group_status_o),
    .message_done_o (message_done_o),
    .byte_total_o   (byte_total_o)
  );

endmodule

>>> sv/bchbd_front.sv
// ----------------------------------------------------------------------------
// bchbd_front
// Accepts groups, computes the syndrome and marks clean groups.
// ----------------------------------------------------------------------------
module bchbd_front (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bchbd_pkg::CwBits-1:0] codeword_i,
  input  logic                         end_of_message_i,
  output logic                         push_o,
  output bchbd_pkg::item_t             item_o,
  input  logic                         full_i
);

  logic [bchbd_pkg::ParBits-1:0] syn;

  // Classify the incoming beat by its syndrome.
  always_comb begin
    syn          = bchbd_pkg::syndrome(codeword_i);
    item_o.cw    = codeword_i;
    item_o.eom   = end_of_message_i;
    item_o.syn   = syn;
    item_o.clean = (syn == '0);
  end

  // Take a beat whenever the queue has room.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

>>> sv/bchbd_queue.sv
// ----------------------------------------------------------------------------
// bchbd_queue
// Small FIFO of classified groups between front and back.
// ----------------------------------------------------------------------------
module bchbd_queue #(
  parameter int Depth = bchbd_pkg::QueueDepthDef  // at least 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bchbd_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bchbd_pkg::item_t item_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  bchbd_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed beat.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> sv/bchbd_back.sv
// ----------------------------------------------------------------------------
// bchbd_back
// Burst search, message accounting and the output register.
// ----------------------------------------------------------------------------
`include "bch_26_16_burst_decoder_assert.svh"

module bchbd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  bchbd_pkg::item_t                q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bchbd_pkg::DataBits-1:0]  data_word_o,
  output logic [1:0]                      group_status_o,
  output logic                            message_done_o,
  output logic [bchbd_pkg::TotalBits-1:0] byte_total_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FIN
  } state_e;

  localparam logic [bchbd_pkg::ShiftBits-1:0] LastK =
    bchbd_pkg::ShiftBits'(bchbd_pkg::BurstSpan - 1);

  state_e                             state_q, state_d;
  logic [bchbd_pkg::CwBits-1:0]       cw_q, cw_d;
  logic                               eom_q, eom_d;
  logic [bchbd_pkg::ParBits-1:0]      r_q, r_d;
  logic [bchbd_pkg::ShiftBits-1:0]    k_q, k_d;
  logic                               found_q, found_d;
  logic [bchbd_pkg::BurstBits-1:0]    best_val_q, best_val_d;
  logic [bchbd_pkg::ShiftBits-1:0]    best_k_q, best_k_d;
  logic [bchbd_pkg::TotalBits-1:0]    good_q, good_d;
  logic                               failed_q, failed_d;
  logic                               out_valid_q, out_valid_d;
  logic [bchbd_pkg::DataBits-1:0]     data_q, data_d;
  bchbd_pkg::status_e                 status_q, status_d;
  logic                               done_q, done_d;
  logic [bchbd_pkg::TotalBits-1:0]    total_q, total_d;

  logic                               slot_free;
  logic                               hit;
  logic                               emit;
  bchbd_pkg::status_e                 e_status;
  logic [bchbd_pkg::DataBits-1:0]     e_data;
  logic                               e_eom;
  logic [bchbd_pkg::CwBits-1:0]       pat;
  logic [bchbd_pkg::CwBits-1:0]       fixed;
  logic [bchbd_pkg::TotalBits:0]      sum;
  logic [bchbd_pkg::TotalBits-1:0]    good_after;
  logic                               failed_after;

  assign slot_free = !out_valid_q || out_ready_i;
  // A residue below x^5 is a burst value that fits at the current shift.
  assign hit   = (r_q[bchbd_pkg::ParBits-1:bchbd_pkg::BurstBits] == '0);
  assign pat   = bchbd_pkg::CwBits'(best_val_q) << best_k_q;
  assign fixed = cw_q ^ pat;
  assign sum   = {1'b0, good_q} + (bchbd_pkg::TotalBits + 1)'(2);

  always_comb begin
    state_d     = state_q;
    cw_d        = cw_q;
    eom_d       = eom_q;
    r_d         = r_q;
    k_d         = k_q;
    found_d     = found_q;
    best_val_d  = best_val_q;
    best_k_d    = best_k_q;
    good_d      = good_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q;
    data_d      = data_q;
    status_d    = status_q;
    done_d      = done_q;
    total_d     = total_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    e_status    = bchbd_pkg::STAT_CLEAN;
    e_data      = '0;
    e_eom       = eom_q;

    // Drop the output beat once taken.
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          e_eom   = q_item_i.eom;
          if (failed_q) begin
            emit     = 1'b1;
            e_status = bchbd_pkg::STAT_SKIP;
          end else if (q_item_i.clean) begin
            emit     = 1'b1;
            e_status = bchbd_pkg::STAT_CLEAN;
            e_data   = q_item_i.cw[bchbd_pkg::CwBits-1:bchbd_pkg::ParBits];
          end else begin
            cw_d    = q_item_i.cw;
            eom_d   = q_item_i.eom;
            r_d     = q_item_i.syn;
            k_d     = '0;
            found_d = 1'b0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // Keep the smallest burst value; on a tie the higher shift wins.
        if (hit && (!found_q || r_q[bchbd_pkg::BurstBits-1:0] <= best_val_q)) begin
          found_d    = 1'b1;
          best_val_d = r_q[bchbd_pkg::BurstBits-1:0];
          best_k_d   = k_q;
        end
        r_d = bchbd_pkg::div_x(r_q);
        if (k_q == LastK) state_d = ST_FIN;
        else k_d = k_q + 1'b1;
      end
      ST_FIN: begin
        if (slot_free) begin
          emit = 1'b1;
          if (found_q) begin
            e_status = bchbd_pkg::STAT_CORR;
            e_data   = fixed[bchbd_pkg::CwBits-1:bchbd_pkg::ParBits];
          end else begin
            e_status = bchbd_pkg::STAT_UNCOR;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Count decoded bytes and close the message on its last group.
    failed_after = failed_q || (e_status == bchbd_pkg::STAT_UNCOR);
    good_after   = good_q;
    if (e_status == bchbd_pkg::STAT_CLEAN || e_status == bchbd_pkg::STAT_CORR) begin
      good_after = (sum > {1'b0, bchbd_pkg::BytesCap}) ? bchbd_pkg::BytesCap
                                                       : sum[bchbd_pkg::TotalBits-1:0];
    end
    if (emit) begin
      out_valid_d = 1'b1;
      data_d      = e_data;
      status_d    = e_status;
      done_d      = e_eom;
      if (e_eom) begin
        total_d  = failed_after ? '0 : good_after;
        good_d   = '0;
        failed_d = 1'b0;
      end else begin
        total_d  = '0;
        good_d   = good_after;
        failed_d = failed_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cw_q        <= '0;
      eom_q       <= 1'b0;
      r_q         <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      best_val_q  <= '0;
      best_k_q    <= '0;
      good_q      <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      data_q      <= '0;
      status_q    <= bchbd_pkg::STAT_CLEAN;
      done_q      <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      cw_q        <= cw_d;
      eom_q       <= eom_d;
      r_q         <= r_d;
      k_q         <= k_d;
      found_q     <= found_d;
      best_val_q  <= best_val_d;
      best_k_q    <= best_k_d;
      good_q      <= good_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
      data_q      <= data_d;
      status_q    <= status_d;
      done_q      <= done_d;
      total_q     <= total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_word_o    = data_q;
  assign group_status_o = status_q;
  assign message_done_o = done_q;
  assign byte_total_o   = total_q;

  `BCHBD_ASSERT(a_pop_in_idle, q_pop_o |-> state_q == ST_IDLE, "pop outside idle")
  `BCHBD_ASSERT(a_search_not_failed, state_q == ST_SEARCH |-> !failed_q, "search after failure")
  `BCHBD_NEVER(a_total_mid_msg, out_valid_q && !done_q && total_q != '0, "total before last group")
  `BCHBD_ASSERT(a_fail_zero_data, out_valid_q && (status_q == bchbd_pkg::STAT_UNCOR || status_q == bchbd_pkg::STAT_SKIP) |-> data_q == '0, "failed group with data")

endmodule
